// File: rtl/nfbia_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nfbia_pkg
// Shared types, constants and helpers of the next-fit bitmap ID allocator.
// ============================================================================
package nfbia_pkg;

    localparam int ID_W     = 12;
    localparam int WORD_W   = 64;
    localparam int WADDR_W  = 6;
    localparam int BIT_W    = 6;
    localparam int NWORDS   = 64;
    localparam int TDATA_W  = 16;
    localparam int CNT_W    = 7;

    // Identifier range; the map holds 4096 identifiers, so the top is clamped.
    localparam int ID_LOW      = 300;
    localparam int ID_HIGH     = 4095;
    localparam int RANGE_HI    = (ID_HIGH > 4095) ? 4095 : ID_HIGH;
    localparam bit RANGE_EMPTY = (ID_LOW > RANGE_HI);

    localparam logic [ID_W-1:0]    ID_LO_C  = ID_W'(ID_LOW);
    localparam logic [ID_W-1:0]    ID_HI_C  = ID_W'(RANGE_HI);
    localparam logic [WADDR_W-1:0] LO_WORD  = WADDR_W'(ID_LOW / WORD_W);
    localparam logic [WADDR_W-1:0] HI_WORD  = WADDR_W'(RANGE_HI / WORD_W);
    localparam logic [BIT_W-1:0]   LO_OFF   = BIT_W'(ID_LOW % WORD_W);
    localparam logic [BIT_W-1:0]   HI_OFF   = BIT_W'(RANGE_HI % WORD_W);
    localparam int                 SPAN_INT = RANGE_EMPTY ? 1
                                            : (RANGE_HI / WORD_W) - (ID_LOW / WORD_W) + 1;
    // The start word is visited twice: once from the pointer up, once below it.
    localparam logic [CNT_W-1:0]   SPAN_WORDS = CNT_W'(SPAN_INT);
    localparam logic [CNT_W-1:0]   SCAN_READS = CNT_W'(SPAN_INT + 1);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_REL   = 1'b1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_REL   = 2'd2;
    localparam logic [1:0] ST_OOR   = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       scan;
        logic       rel_rd;
        logic       wr_alloc;
        logic       wr_rel;
        logic       load_out;
        logic [1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic in_range;
        logic out_free;
    } sts_t;

    function automatic logic in_range(input logic [ID_W-1:0] id);
        in_range = (id >= ID_LO_C) && (id <= ID_HI_C) && !RANGE_EMPTY;
    endfunction

endpackage

// File: rtl/nfbia_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// nfbia_ctrl
// Sequencer for allocate and release requests; drives the datapath.
// ============================================================================
module nfbia_ctrl
    import nfbia_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_kind,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_AWR  = 3'd2;
    localparam logic [2:0] S_RRD  = 3'd3;
    localparam logic [2:0] S_RWR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == KIND_ALLOC)
                    begin
                        if (RANGE_EMPTY)
                        begin
                            status_next = ST_NONE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (sts.in_range)
                    begin
                        state_next = S_RRD;
                    end
                    else
                    begin
                        status_next = ST_OOR;
                        state_next  = S_FIN;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (sts.hit)
                begin
                    state_next = S_AWR;
                end
                else if (sts.exhausted)
                begin
                    status_next = ST_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_AWR:
            begin
                status_next = ST_ALLOC;
                state_next  = S_FIN;
            end
            S_RRD:
            begin
                state_next = S_RWR;
            end
            S_RWR:
            begin
                status_next = ST_REL;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.capture    = (state_reg == S_IDLE) && in_valid;
        cmd.scan       = (state_reg == S_SCAN);
        cmd.rel_rd     = (state_reg == S_RRD);
        cmd.wr_alloc   = (state_reg == S_AWR);
        cmd.wr_rel     = (state_reg == S_RWR);
        cmd.load_out   = (state_reg == S_FIN) && sts.out_free;
        cmd.out_status = status_reg;
    end

endmodule

// File: rtl/nfbia_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// nfbia_dp
// Used-bit map memory, word scan pipeline, next-fit pointer, output register.
// ============================================================================
module nfbia_dp
    import nfbia_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cmd_t            cmd,
    input  logic [ID_W-1:0] in_id,
    output sts_t            sts,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [ID_W-1:0] out_id,
    output logic [1:0]      out_status
);

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] ONE  = {{(WORD_W-1){1'b0}}, 1'b1};

    logic [WORD_W-1:0]  mem [NWORDS];
    logic [NWORDS-1:0]  vld_reg;

    logic [ID_W-1:0]    req_id_reg;
    logic [ID_W-1:0]    next_ptr_reg;
    logic [BIT_W-1:0]   start_off_reg;
    logic [WADDR_W-1:0] iss_addr_reg;
    logic [CNT_W-1:0]   iss_cnt_reg;
    logic               chk_valid_reg;
    logic [WADDR_W-1:0] chk_addr_reg;
    logic [CNT_W-1:0]   chk_cnt_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_vld_reg;
    logic [ID_W-1:0]    grant_reg;
    logic [WADDR_W-1:0] wr_addr_reg;
    logic [WORD_W-1:0]  wr_data_reg;
    logic               out_vld_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [1:0]         out_status_reg;

    logic [ID_W-1:0]    start_pos;
    logic               scan_rd;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic [WADDR_W-1:0] iss_addr_next;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  up_bits;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  cand;
    logic [WORD_W-1:0]  lowbit;
    logic [BIT_W-1:0]   hit_idx;
    logic               any_free;
    logic [WORD_W-1:0]  rel_data;

    // Bits of word a whose identifiers lie inside the range.
    function automatic logic [WORD_W-1:0] range_mask(input logic [WADDR_W-1:0] a);
        logic [WORD_W-1:0] m;
        m = ONES;
        if (a < LO_WORD || a > HI_WORD)
        begin
            m = '0;
        end
        else
        begin
            if (a == LO_WORD)
            begin
                m = m & (ONES << LO_OFF);
            end
            if (a == HI_WORD)
            begin
                m = m & (ONES >> (BIT_W'(WORD_W - 1) - HI_OFF));
            end
        end
        range_mask = m;
    endfunction

    function automatic logic [BIT_W-1:0] encode(input logic [WORD_W-1:0] oh);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (oh[b])
            begin
                idx = idx | BIT_W'(b);
            end
        end
        encode = idx;
    endfunction

    always_comb
    begin
        start_pos     = in_range(next_ptr_reg) ? next_ptr_reg : ID_LO_C;
        scan_rd       = cmd.scan && (iss_cnt_reg != SCAN_READS);
        rd_en         = scan_rd || cmd.rel_rd;
        rd_addr       = cmd.rel_rd ? req_id_reg[ID_W-1:BIT_W] : iss_addr_reg;
        iss_addr_next = (iss_addr_reg == HI_WORD) ? LO_WORD : iss_addr_reg + 1'b1;

        word    = rd_vld_reg ? rd_data_reg : '0;
        up_bits = ONES << start_off_reg;
        mask    = range_mask(chk_addr_reg);
        if (chk_cnt_reg == '0)
        begin
            mask = mask & up_bits;
        end
        else if (chk_cnt_reg == SPAN_WORDS)
        begin
            mask = mask & ~up_bits;
        end
        cand     = ~word & mask;
        lowbit   = cand & (~cand + ONE);
        hit_idx  = encode(lowbit);
        any_free = |cand;
        rel_data = word & ~(ONE << req_id_reg[BIT_W-1:0]);
    end

    always_comb
    begin
        sts.hit       = chk_valid_reg && any_free;
        sts.exhausted = chk_valid_reg && !any_free && (chk_cnt_reg == SPAN_WORDS);
        sts.in_range  = in_range(in_id);
        sts.out_free  = !out_vld_reg || out_ready;
    end

    // Map memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_alloc)
        begin
            mem[wr_addr_reg] <= wr_data_reg;
        end
        else if (cmd.wr_rel)
        begin
            mem[req_id_reg[ID_W-1:BIT_W]] <= rel_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // A word never written reads as all clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.wr_alloc)
        begin
            vld_reg[wr_addr_reg] <= 1'b1;
        end
        else if (cmd.wr_rel)
        begin
            vld_reg[req_id_reg[ID_W-1:BIT_W]] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg   <= '0;
            chk_valid_reg <= 1'b0;
            next_ptr_reg  <= ID_LO_C;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            chk_valid_reg <= scan_rd;
            if (cmd.capture)
            begin
                iss_cnt_reg <= '0;
            end
            else if (scan_rd)
            begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                if (cmd.out_status == ST_ALLOC)
                begin
                    next_ptr_reg <= grant_reg;
                end
                else if (cmd.out_status == ST_NONE)
                begin
                    next_ptr_reg <= ID_LO_C;
                end
            end
            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_id_reg    <= in_id;
            start_off_reg <= start_pos[BIT_W-1:0];
            iss_addr_reg  <= start_pos[ID_W-1:BIT_W];
        end
        else if (scan_rd)
        begin
            iss_addr_reg <= iss_addr_next;
        end
        if (scan_rd)
        begin
            chk_addr_reg <= iss_addr_reg;
            chk_cnt_reg  <= iss_cnt_reg;
        end
        if (cmd.scan && sts.hit)
        begin
            grant_reg   <= {chk_addr_reg, hit_idx};
            wr_addr_reg <= chk_addr_reg;
            wr_data_reg <= word | lowbit;
        end
        if (cmd.load_out)
        begin
            out_id_reg     <= (cmd.out_status == ST_ALLOC) ? grant_reg : '0;
            out_status_reg <= cmd.out_status;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_id     = out_id_reg;
    assign out_status = out_status_reg;

endmodule

// File: rtl/next_fit_bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// next_fit_bitmap_id_allocator
// Next-fit identifier allocator over a 4096-bit used map.
// ============================================================================
// Usage:
//   Send one request word on the s_ channel: tuser[0] selects allocate (0)
//   or release (1), tdata carries the identifier to free. Every request
//   returns exactly one result word on the m_ channel: tdata holds the
//   granted identifier (zero unless allocated), tuser holds the status.
//   Only one request is in flight; s_tready is high while the sequencer idles.
//   A release reads the identifier's map word, writes it back with the bit
//   cleared, then loads the result register. An allocate reads one 64-bit
//   map word per cycle from the next-fit pointer, writes the word with the
//   granted bit set (no write when refused), then loads the result; the worst
//   case visits every word of the range plus the start word again (61 words
//   for the default range). s_tready rises in the cycle after the result register loads.
//   Reset returns the pointer to the bottom of the range and clears the
//   per-word valid flags at once, so the whole map reads as free right after reset with no clearing sweep.
//   When m_tready is low the result word holds in the output register; the
//   next request may still be accepted, but its result waits until the
//   output register drains.
// ============================================================================
module next_fit_bitmap_id_allocator
    import nfbia_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [11:0] release_id, [15:12] zero
    input  logic [0:0]         s_tuser,   // [0] kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [11:0] granted_id, [15:12] zero
    output logic [1:0]         m_tuser    // [1:0] status
);

    cmd_t            cmd;
    sts_t            sts;
    logic [ID_W-1:0] granted_id;

    // Sequencer: decides the next step from the datapath status.
    nfbia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser[0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Map, scan pipeline, pointer and result register.
    nfbia_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_id      (s_tdata[ID_W-1:0]),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_id     (granted_id),
        .out_status (m_tuser)
    );

    // Pad the identifier to whole bytes.
    assign m_tdata = {{(TDATA_W-ID_W){1'b0}}, granted_id};

endmodule

// File: rtl/nfbia_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// nfbia_checker
// Port-level checks of the ID allocator, bound to the top level.
// ============================================================================
module nfbia_checker
    import nfbia_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic [0:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A granted identifier lies inside the range.
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_ALLOC) |->
            (m_tdata[ID_W-1:0] >= ID_LO_C) && (m_tdata[ID_W-1:0] <= ID_HI_C))
        else $error("granted identifier outside range");

    // Identifier field is zero unless something was allocated.
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_ALLOC) |-> (m_tdata == '0))
        else $error("nonzero identifier without a grant");

    // One request at a time: ready drops right after an accept.
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

endmodule

bind next_fit_bitmap_id_allocator nfbia_checker u_nfbia_checker (.*);

// File: test/next_fit_bitmap_id_allocator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// next_fit_bitmap_id_allocator_tb
// Self-checking bench for the next-fit bitmap ID allocator.
// ============================================================================
// A driver streams allocate and release requests from a pending queue in
// random bursts. Every accepted word is run through a bit-level allocator
// model here, and the expected grant lands in a queue. The monitor stalls
// m_tready on shifting patterns and checks each result word against the
// oldest expected grant.
// Stimulus order:
//   - a directed opening: range edges, next-fit skip over a freed hole,
//     releases of free and out-of-range identifiers
//   - a random mix
//   - a long allocation run that pushes the pointer well up the range
//   - churn of allocations and releases over the whole range
// ============================================================================
module next_fit_bitmap_id_allocator_tb;
    import nfbia_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_PRINTS  = 40;
    localparam int RANGE_SIZE  = RANGE_EMPTY ? 0 : RANGE_HI - ID_LOW + 1;
    localparam int MIX_ITEMS   = 450;
    localparam int RUN_ITEMS   = 380;
    localparam int CHURN_ITEMS = 400;

    typedef struct {
        logic            kind;
        logic [ID_W-1:0] id;
        bit              drain;   // wait for every outstanding result first
    } req_t;

    typedef struct {
        logic [ID_W-1:0] granted;
        logic [1:0]      status;
    } grant_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    next_fit_bitmap_id_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Allocator model: its own used map and next-fit pointer
    // ------------------------------------------------------------------------
    bit [4095:0]     id_taken;
    logic [ID_W-1:0] fit_ptr;

    req_t   req_q[$];     // requests not yet accepted
    grant_t grant_q[$];   // expected result words, oldest first

    int n_errors    = 0;
    int n_accepted  = 0;
    int n_granted   = 0;
    int n_exhausted = 0;
    int n_released  = 0;
    int n_ignored   = 0;

    function automatic grant_t predict_grant(input req_t r);
        grant_t          g;
        logic [ID_W-1:0] pos;
        bit              found;
        g.granted = '0;
        g.status  = ST_NONE;
        found     = 1'b0;
        if (r.kind == KIND_REL)
        begin
            if (!RANGE_EMPTY && r.id >= ID_LOW && r.id <= RANGE_HI)
            begin
                id_taken[r.id] = 1'b0;
                g.status       = ST_REL;
            end
            else
                g.status = ST_OOR;
        end
        else
        begin
            if (!RANGE_EMPTY)
            begin
                // Start from the pointer when it sits inside the range.
                pos = (fit_ptr >= ID_LOW && fit_ptr <= RANGE_HI) ? fit_ptr : ID_LO_C;
                for (int n = 0; n < RANGE_SIZE && !found; n++)
                begin
                    if (!id_taken[pos])
                    begin
                        id_taken[pos] = 1'b1;
                        g.granted     = pos;
                        g.status      = ST_ALLOC;
                        found         = 1'b1;
                    end
                    else
                        pos = (pos >= ID_HI_C) ? ID_LO_C : pos + 1'b1;
                end
            end
            // A failed scan sends the pointer back to the bottom.
            fit_ptr = found ? g.granted : ID_LO_C;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (n_errors < MAX_PRINTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of words with random gaps, hold valid until accepted
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;
    bit hold_word;
    bit present;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            id_taken = '0;
            fit_ptr  = ID_LO_C;
        end
        else
        begin
            hold_word = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                grant_q.push_back(predict_grant(req_q.pop_front()));
                n_accepted++;
                hold_word = 1'b0;
            end
            if (!hold_word)
            begin
                present = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (req_q.size() != 0 && !(req_q[0].drain && grant_q.size() != 0))
                begin
                    present = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                s_tvalid <= present;
                if (present)
                begin
                    s_tdata <= TDATA_W'(req_q[0].id);
                    s_tuser <= req_q[0].kind;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall pattern on m_tready, check each result word
    // ------------------------------------------------------------------------
    int     stall_mode  = 0;
    int     mode_left   = 0;
    int     stall_every = 4;
    int     stall_phase = 0;
    bit     rdy_next;
    grant_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (grant_q.size() == 0)
                    report_mismatch("unexpected result word (status)", 0, m_tuser);
                else
                begin
                    want = grant_q.pop_front();
                    if (m_tdata !== TDATA_W'(want.granted))
                        report_mismatch("granted_id", want.granted, m_tdata);
                    if (m_tuser !== want.status)
                        report_mismatch("status", want.status, m_tuser);
                end
                case (m_tuser)
                    ST_ALLOC: n_granted++;
                    ST_NONE:  n_exhausted++;
                    ST_REL:   n_released++;
                    default:  n_ignored++;
                endcase
            end
            // Switch among always ready, coin flip, mostly ready, and one in N.
            if (mode_left == 0)
            begin
                stall_mode  = $urandom_range(0, 3);
                mode_left   = $urandom_range(64, 400);
                stall_every = $urandom_range(2, 12);
            end
            else
                mode_left--;
            stall_phase = (stall_phase + 1) % stall_every;
            case (stall_mode)
                0:       rdy_next = 1'b1;
                1:       rdy_next = $urandom_range(0, 1);
                2:       rdy_next = ($urandom_range(0, 3) != 0);
                default: rdy_next = (stall_phase == 0);
            endcase
            m_tready <= rdy_next;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     grant_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_req(input logic kind, input logic [ID_W-1:0] id, input bit drain);
        req_t r;
        r.kind  = kind;
        r.id    = id;
        r.drain = drain;
        req_q.push_back(r);
    endtask

    // Release target: mostly in range, some below the range, some raw bits.
    function automatic logic [ID_W-1:0] pick_release(input int hot_top);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ID_W'($urandom_range(ID_LOW, hot_top));
            4, 5, 6, 7: return ID_W'($urandom_range(ID_LOW, RANGE_HI));
            8:          return ID_W'($urandom_range(0, ID_LOW - 1));
            default:    return ID_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int hot_top;

        // Directed opening: grants start at the bottom of the range.
        add_req(KIND_ALLOC, '0, 1'b0);
        add_req(KIND_ALLOC, '1, 1'b0);
        add_req(KIND_ALLOC, 12'h555, 1'b0);
        add_req(KIND_REL, ID_W'(ID_LOW + 1), 1'b0);
        // Next fit moves on instead of reusing the hole just freed.
        add_req(KIND_ALLOC, 12'haaa, 1'b0);
        add_req(KIND_REL, ID_W'(ID_LOW + 1), 1'b0);        // already free
        add_req(KIND_REL, '0, 1'b0);                       // below range, all zeros
        add_req(KIND_REL, ID_W'(ID_LOW - 1), 1'b0);        // just below range
        add_req(KIND_REL, ID_LO_C, 1'b0);                  // bottom edge
        add_req(KIND_REL, ID_HI_C, 1'b0);                  // top edge, all ones
        add_req(KIND_REL, 12'h555, 1'b0);
        add_req(KIND_REL, 12'haaa, 1'b0);
        add_req(KIND_ALLOC, '0, 1'b1);
        add_req(KIND_ALLOC, '0, 1'b0);
        add_req(KIND_REL, ID_W'(ID_LOW + 3), 1'b0);
        add_req(KIND_ALLOC, '1, 1'b0);

        // Random mix, allocation heavy so the pointer keeps moving up.
        for (int i = 0; i < MIX_ITEMS; i++)
        begin
            hot_top = ID_LOW + 2 * i + 8;
            if (hot_top > RANGE_HI)
                hot_top = RANGE_HI;
            if ($urandom_range(0, 9) < 7)
                add_req(KIND_ALLOC, ID_W'($urandom), i == 0 || $urandom_range(0, 99) == 0);
            else
                add_req(KIND_REL, pick_release(hot_top), i == 0);
        end

        // Long allocation run: every grant lands above the ones before it.
        for (int i = 0; i < RUN_ITEMS; i++)
            add_req(KIND_ALLOC, ID_W'($urandom), i == 0 || $urandom_range(0, 99) == 0);

        // Churn: releases all over the range leave holes behind the pointer.
        for (int i = 0; i < CHURN_ITEMS; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                add_req(KIND_ALLOC, ID_W'($urandom), i == 0);
            else
                add_req(KIND_REL, pick_release(RANGE_HI), 1'b0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || grant_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests: %0d grants, %0d refused on a full map, %0d frees, %0d ignored",
                 n_accepted, n_granted, n_exhausted, n_released, n_ignored);
        $display("%0d mismatches over %0d cycles", n_errors, cycles);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: next_fit_bitmap_id_allocator.f
rtl/nfbia_pkg.sv
rtl/nfbia_ctrl.sv
rtl/nfbia_dp.sv
rtl/next_fit_bitmap_id_allocator.sv
rtl/nfbia_checker.sv
test/next_fit_bitmap_id_allocator_tb.sv
